// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the palette mapper.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/dpm_pkg.sv
// Package of the dithered palette mapper: sequencer states and constants.
// Depends on nothing; used by dithered_palette_mapper.
package dpm_pkg;

	localparam int ROW_LIMIT = 4096;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_RD0   = 7'b0000010,
		ST_RD1   = 7'b0000100,
		ST_SHARE = 7'b0001000,
		ST_SRCH  = 7'b0010000,
		ST_WB    = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_PIXEL = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		REG_PALETTE_SIZE = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2,
		REG_DITHER       = 2'd3
	} reg_idx_t;

	// Clamped add of one error share to an 8-bit channel.
	function automatic logic [7:0] add_share(input logic [7:0] px,
		input logic signed [8:0] err, input logic [2:0] wt);
		logic signed [12:0] prod;
		logic signed [12:0] mag;
		logic signed [12:0] share;
		logic signed [12:0] sum;
		prod = 13'(err) * $signed({10'd0, wt});
		mag = prod[12] ? -prod : prod;
		share = prod[12] ? -(mag >>> 4) : (mag >>> 4);
		sum = $signed({5'd0, px}) + share;
		if (sum < 0)
			add_share = 8'd0;
		else if (sum > 13'sd255)
			add_share = 8'd255;
		else
			add_share = sum[7:0];
	endfunction

endpackage

// File: rtl/dithered_palette_mapper.sv
// Top level of the dithered palette mapper: palette search and error diffusion.
// Depends on dpm_pkg and assert_macros.svh.
//
// Usage: the input channel (in_valid/in_ready) carries palette-write items
// (func 0) and pixel items (func 1) in raster order. A palette write gives
// no result and leaves the block idle; in_ready stays high, so writes can
// follow back to back. A pixel item reads the row error line, adds up to four
// error shares one per cycle, then searches the palette one entry per cycle.
// It then writes its error to the row line and registers its result. The
// block takes one item at a time; in_ready is high only when idle. The result
// item (color_index, frame_last) is held in an output register until
// out_ready; a stall on out_ready holds off the next item. Reset clears the
// position, the left and above-left errors and the registers to their
// defaults; palette and row memories hold nothing defined until written.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are to be made only while the block is idle; the block does not enforce it.
`include "assert_macros.svh"

module dithered_palette_mapper #(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_PALETTE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  entry_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  color_index,
	output logic        frame_last
);
	import dpm_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int PW = (MAX_PALETTE > 2) ? $clog2(MAX_PALETTE) : 1;

	logic [23:0] pal_mem [MAX_PALETTE];
	logic [26:0] row_mem [MAX_WIDTH];

	state_t state_q;
	logic [8:0]  psize_q;
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic        dither_q;

	logic [XW-1:0] col_q;
	logic [11:0]   row_q;
	logic [26:0]   left_q, aleft_q, above_q, aright_q;
	logic [7:0]    px_q [3];
	logic [1:0]    sh_q;
	logic [8:0]    srch_q;
	logic [PW-1:0] best_q;
	logic [17:0]   bd_q;
	logic [23:0]   pal_rd_q, best_col_q;
	logic          first_q;
	logic          ilast_q;

	// Effective configuration.
	logic [8:0]  psz;
	logic [10:0] wid;
	logic [12:0] hgt;
	logic        last_col, last_row;
	always_comb begin
		psz = (psize_q == 9'd0) ? 9'd1 :
			(psize_q > 9'(MAX_PALETTE)) ? 9'(MAX_PALETTE) : psize_q;
		wid = (width_q == 11'd0) ? 11'd1 :
			(int'(width_q) > MAX_WIDTH) ? 11'(MAX_WIDTH) : width_q;
		hgt = (height_q == 13'd0) ? 13'd1 :
			(height_q > 13'(ROW_LIMIT)) ? 13'(ROW_LIMIT) : height_q;
		last_col = ({1'b0, 11'(col_q)} + 12'd1) >= {1'b0, wid};
		last_row = ({1'b0, row_q} + 13'd1) >= hgt;
	end

	// One share a cycle through the shared clamp-add unit.
	logic [26:0] sh_err;
	logic [2:0]  sh_wt;
	logic        sh_en;
	always_comb begin
		sh_err = left_q;
		sh_wt = 3'd7;
		sh_en = 1'b0;
		case (sh_q)
			2'd0: begin
				sh_err = aleft_q; sh_wt = 3'd1;
				sh_en = dither_q && (row_q != 12'd0) && (col_q != '0);
			end
			2'd1: begin
				sh_err = above_q; sh_wt = 3'd5;
				sh_en = dither_q && (row_q != 12'd0);
			end
			2'd2: begin
				sh_err = aright_q; sh_wt = 3'd3;
				sh_en = dither_q && (row_q != 12'd0) && !last_col;
			end
			default: begin
				sh_err = left_q; sh_wt = 3'd7;
				sh_en = dither_q && (col_q != '0);
			end
		endcase
	end

	// Shared squared-distance unit.
	logic signed [8:0]  dr, dg, db;
	logic signed [17:0] sq_r, sq_g, sq_b;
	logic [17:0] sq_dist;
	always_comb begin
		dr = $signed({1'b0, px_q[0]}) - $signed({1'b0, pal_rd_q[23:16]});
		dg = $signed({1'b0, px_q[1]}) - $signed({1'b0, pal_rd_q[15:8]});
		db = $signed({1'b0, px_q[2]}) - $signed({1'b0, pal_rd_q[7:0]});
		sq_r = dr * dr;
		sq_g = dg * dg;
		sq_b = db * db;
		sq_dist = $unsigned(sq_r) + $unsigned(sq_g) + $unsigned(sq_b);
	end

	logic [8:0] err_r, err_g, err_b;
	logic [26:0] err_new;
	always_comb begin
		err_r = 9'({1'b0, px_q[0]} - {1'b0, best_col_q[23:16]});
		err_g = 9'({1'b0, px_q[1]} - {1'b0, best_col_q[15:8]});
		err_b = 9'({1'b0, px_q[2]} - {1'b0, best_col_q[7:0]});
		err_new = dither_q ? {err_r, err_g, err_b} : 27'd0;
	end

	logic [XW-1:0] col_next;
	assign col_next = last_col ? col_q : col_q + XW'(1);

	assign in_ready = (state_q == ST_IDLE);

	// Memories.
	logic [PW-1:0] pal_addr;
	assign pal_addr = srch_q[PW-1:0];
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && func == FUNC_WRITE
			&& {1'b0, entry_index} < 9'(MAX_PALETTE))
			pal_mem[entry_index[PW-1:0]] <= {red, green, blue};
		pal_rd_q <= pal_mem[pal_addr];
	end

	logic [26:0] row_rd_q;
	logic [XW-1:0] row_addr;
	assign row_addr = (state_q == ST_RD0) ? col_q : col_next;
	always_ff @(posedge clk) begin
		if (state_q == ST_WB)
			row_mem[col_q] <= err_new;
		row_rd_q <= row_mem[row_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			psize_q <= 9'd2;
			width_q <= 11'd1024;
			height_q <= 13'd1;
			dither_q <= 1'b1;
			col_q <= '0;
			row_q <= '0;
			left_q <= '0;
			aleft_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_PALETTE_SIZE: psize_q <= cfg_data[8:0];
					REG_IMAGE_WIDTH:  width_q <= cfg_data[10:0];
					REG_IMAGE_HEIGHT: height_q <= cfg_data;
					REG_DITHER:       dither_q <= cfg_data[0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					px_q[0] <= red;
					px_q[1] <= green;
					px_q[2] <= blue;
					if (func == FUNC_PIXEL)
						state_q <= ST_RD0;
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: begin
					above_q <= row_rd_q;
					sh_q <= 2'd0;
					state_q <= ST_SHARE;
				end
				ST_SHARE: begin
					if (sh_q == 2'd1)
						aright_q <= row_rd_q;
					if (sh_en) begin
						px_q[0] <= add_share(px_q[0], sh_err[26:18], sh_wt);
						px_q[1] <= add_share(px_q[1], sh_err[17:9], sh_wt);
						px_q[2] <= add_share(px_q[2], sh_err[8:0], sh_wt);
					end
					sh_q <= sh_q + 2'd1;
					if (sh_q == 2'd3) begin
						srch_q <= 9'd0;
						first_q <= 1'b1;
						ilast_q <= 1'b0;
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					// srch_q addresses the read; pal_rd_q holds entry srch_q-1.
					if (!first_q && (ilast_q || sq_dist < bd_q)) begin
						if (sq_dist < bd_q) begin
							bd_q <= sq_dist;
							best_q <= PW'(srch_q - 9'd1);
							best_col_q <= pal_rd_q;
						end
					end
					if (!first_q && srch_q == 9'd1) begin
						bd_q <= sq_dist;
						best_q <= '0;
						best_col_q <= pal_rd_q;
					end
					first_q <= 1'b0;
					if (srch_q == psz)
						state_q <= ST_WB;
					else
						srch_q <= srch_q + 9'd1;
				end
				ST_WB: begin
					// The last entry was compared in the final search cycle, so the
					// best match is settled and its error goes to the row line here.
					state_q <= ST_OUT;
				end
				ST_OUT: if (!out_valid) begin
					aleft_q <= above_q;
					left_q <= err_new;
					frame_last <= last_col && last_row;
					color_index <= 8'(best_q);
					out_valid <= 1'b1;
					if (last_col) begin
						col_q <= '0;
						row_q <= last_row ? 12'd0 : row_q + 12'd1;
					end else
						col_q <= col_next;
				end else if (out_ready) begin
					out_valid <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_ready_idle, clk, arst_n, in_ready, !out_valid, "ready while result pending")
	`ASSERT_NEXT(a_pix_start, clk, arst_n, in_valid && in_ready && func == FUNC_PIXEL,
		state_q == ST_RD0, "pixel did not start lookup")
	`ASSERT_IMPL(a_srch_bound, clk, arst_n, state_q == ST_SRCH, srch_q <= psz,
		"search index past palette size")
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(color_index),
		"result dropped while stalled")

endmodule

// File: test/dithered_palette_mapper_tb.sv
// Self-checking testbench of dithered_palette_mapper: random and directed items
// against a scoreboard that predicts palette search and error diffusion.
// Depends on dpm_pkg and the RTL of dithered_palette_mapper.
`timescale 1ns / 100ps

module dithered_palette_mapper_tb;
	import dpm_pkg::*;

	typedef struct {
		logic [7:0] color_index;
		logic       frame_last;
	} mapped_pixel_t;

	// Scoreboard: keeps its own copy of palette, error line, position and
	// registers, and queues the mapped pixel expected for every pixel item.
	class pixel_scoreboard;
		logic [23:0]   palette [256];
		int            err_line [1024][3];
		int            above_left [3];
		int            left_err [3];
		int            col;
		int            row;
		int            pal_size;
		int            width;
		int            height;
		bit            dither;
		mapped_pixel_t pending [$];
		int            errors;

		function new();
			foreach (palette[i]) palette[i] = '0;
			foreach (err_line[i, k]) err_line[i][k] = 0;
			foreach (above_left[k]) begin
				above_left[k] = 0;
				left_err[k] = 0;
			end
			col = 0;
			row = 0;
			pal_size = 2;
			width = 1024;
			height = 1;
			dither = 1;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [12:0] value);
			case (idx)
				REG_PALETTE_SIZE: pal_size = value[8:0];
				REG_IMAGE_WIDTH:  width = value[10:0];
				REG_IMAGE_HEIGHT: height = value[12:0];
				REG_DITHER:       dither = value[0];
			endcase
		endfunction

		static function int clip(int v, int hi);
			if (v == 0)
				return 1;
			return (v > hi) ? hi : v;
		endfunction

		// Adds one weighted share per channel, clamping after each addition.
		static function void diffuse(ref int px[3], input int e[3], input int wt);
			int s;
			for (int k = 0; k < 3; k++) begin
				s = px[k] + (e[k] * wt) / 16;
				px[k] = (s < 0) ? 0 : ((s > 255) ? 255 : s);
			end
		endfunction

		function void note_input(func_t f, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
			int            px [3];
			int            e [3];
			int            psz;
			int            w;
			int            h;
			int            x;
			int            best;
			int            bd;
			int            d;
			int            dr;
			int            dg;
			int            db;
			bit            last_col;
			bit            last_row;
			mapped_pixel_t res;
			if (f == FUNC_WRITE) begin
				palette[idx] = {r, g, b};
				return;
			end
			px[0] = r;
			px[1] = g;
			px[2] = b;
			psz = clip(pal_size, 256);
			w = clip(width, 1024);
			h = clip(height, ROW_LIMIT);
			x = (col >= 1024) ? 1023 : col;
			last_col = (x + 1 >= w);
			last_row = (row + 1 >= h);
			if (dither) begin
				// The top row has no row above, the first column nothing to its left.
				if (row > 0) begin
					if (x > 0)
						diffuse(px, above_left, 1);
					diffuse(px, err_line[x], 5);
					if (!last_col)
						diffuse(px, err_line[x + 1], 3);
				end
				if (x > 0)
					diffuse(px, left_err, 7);
			end
			best = 0;
			bd = 32'h7fffffff;
			for (int i = 0; i < psz; i++) begin
				dr = px[0] - palette[i][23:16];
				dg = px[1] - palette[i][15:8];
				db = px[2] - palette[i][7:0];
				d = dr * dr + dg * dg + db * db;
				if (d < bd) begin
					bd = d;
					best = i;
				end
			end
			e[0] = dither ? px[0] - palette[best][23:16] : 0;
			e[1] = dither ? px[1] - palette[best][15:8] : 0;
			e[2] = dither ? px[2] - palette[best][7:0] : 0;
			above_left = err_line[x];
			err_line[x] = e;
			left_err = e;
			if (last_col) begin
				col = 0;
				row = last_row ? 0 : row + 1;
			end else begin
				col = x + 1;
			end
			res.color_index = best[7:0];
			res.frame_last = last_col && last_row;
			pending.push_back(res);
		endfunction

		function void check_result(logic [7:0] ci, logic fl);
			mapped_pixel_t exp_px;
			if (pending.size() == 0) begin
				$display("%0t: unexpected item color_index %0d frame_last %0d", $time, ci, fl);
				errors++;
				return;
			end
			exp_px = pending.pop_front();
			if (ci !== exp_px.color_index) begin
				$display("%0t: color_index expected %0d actual %0d", $time,
					exp_px.color_index, ci);
				errors++;
			end
			if (fl !== exp_px.frame_last) begin
				$display("%0t: frame_last expected %0d actual %0d", $time,
					exp_px.frame_last, fl);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        func;
	logic [7:0]  entry_index;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  color_index;
	logic        frame_last;

	pixel_scoreboard sb;

	// Set by the stimulus to make the receiver stall for a long stretch.
	bit hold_off_req;
	// While set, neither side inserts idle cycles.
	bit no_idle;
	int quiet_cycles;

	dithered_palette_mapper dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .entry_index(entry_index),
		.red(red), .green(green), .blue(blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.color_index(color_index), .frame_last(frame_last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Monitor: both handshakes are sampled at the edge, before any driver update
	// of that edge lands, so the values seen are the ones that were accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input(func_t'(func), entry_index, red, green, blue);
			if (out_valid && out_ready)
				sb.check_result(color_index, frame_last);
		end
	end

	// Watchdog: too many cycles without any accepted item on either side
	// means the block has hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 20000) begin
			$display("dithered_palette_mapper_tb NOT OK");
			$finish;
		end
	end

	// Receiver: a random number of idle cycles before each item, plus one long
	// stall on request so the block backs up and holds off the sender.
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
			end
			gap = no_idle ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offers one item and returns at the edge where it was taken. Valid stays
	// high on return, so a following item with no gap keeps it high.
	task automatic send_item(func_t f, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
		logic [7:0] b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		entry_index <= idx;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		send_item(FUNC_PIXEL, 8'($urandom), r, g, b);
	endtask

	// Stops offering and waits until every mapped pixel has come back. The
	// first edge lets the monitor note an item taken at the calling edge.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [12:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		sb.write_reg(idx, value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Picks a setting per register, with the extremes and out-of-range values
	// common, and mostly small palettes and frames to keep the run short.
	task automatic random_config();
		logic [12:0] v;
		case ($urandom_range(0, 9))
			0: v = 13'd0;
			1: v = 13'd1;
			2: v = 13'd256;
			3: v = 13'($urandom_range(257, 511));
			default: v = 13'($urandom_range(2, 24));
		endcase
		write_reg(REG_PALETTE_SIZE, v);
		case ($urandom_range(0, 9))
			0: v = 13'd0;
			1: v = 13'd1;
			2: v = 13'd1024;
			3: v = 13'($urandom_range(1025, 2047));
			default: v = 13'($urandom_range(2, 12));
		endcase
		write_reg(REG_IMAGE_WIDTH, v);
		case ($urandom_range(0, 9))
			0: v = 13'd0;
			1: v = 13'd1;
			2: v = 13'd4096;
			3: v = 13'($urandom_range(4097, 8191));
			default: v = 13'($urandom_range(2, 6));
		endcase
		write_reg(REG_IMAGE_HEIGHT, v);
		write_reg(REG_DITHER, 13'($urandom_range(0, 3) != 0));
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PALETTE_SIZE;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_WRITE;
		entry_index = '0;
		red = '0;
		green = '0;
		blue = '0;
		hold_off_req = 1'b0;
		no_idle = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole palette so that no search ever reads an unwritten entry.
		for (int i = 0; i < 256; i++)
			send_item(FUNC_WRITE, 8'(i), 8'($urandom), 8'($urandom), 8'($urandom));

		// One full 1024-pixel row at the reset settings writes every entry of the
		// error line; from here on any width or position reads defined errors.
		no_idle = 1'b1;
		for (int i = 0; i < 1024; i++)
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		no_idle = 1'b0;
		drain();

		// Directed part: a small frame with a full palette, channel extremes,
		// a tie between two equal entries, then a tie again with dithering off and a two-entry palette.
		write_reg(REG_PALETTE_SIZE, 13'd256);
		write_reg(REG_IMAGE_WIDTH, 13'd3);
		write_reg(REG_IMAGE_HEIGHT, 13'd2);
		send_item(FUNC_WRITE, 8'd0, 8'd10, 8'd20, 8'd30);
		send_item(FUNC_WRITE, 8'd1, 8'd10, 8'd20, 8'd30);
		send_item(FUNC_WRITE, 8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(8'd10, 8'd20, 8'd30);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		drain();
		write_reg(REG_DITHER, 13'd0);
		write_reg(REG_PALETTE_SIZE, 13'd2);
		for (int i = 0; i < 4; i++)
			send_pixel(8'd10, 8'd20, 8'd30);
		send_pixel(8'd255, 8'd255, 8'd255);
		drain();
		// Shrinking the width while mid-row makes the next pixel close the row.
		write_reg(REG_IMAGE_WIDTH, 13'd1);
		write_reg(REG_DITHER, 13'd1);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd1, 8'd254, 8'd127);
		drain();

		// Random phases, each with its own settings. Most items are pixels; some
		// rewrite palette entries between them.
		for (int phase = 0; phase < 8; phase++) begin
			random_config();
			no_idle = (phase % 4 == 1);
			if (phase == 3)
				hold_off_req = 1'b1;
			for (int n = 0; n < 16; n++) begin
				if (phase == 6 && n == 8)
					drain();
				if ($urandom_range(0, 9) == 0)
					send_item(FUNC_WRITE, 8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom));
				else
					send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
			end
			drain();
		end

		no_idle = 1'b0;
		drain();
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("dithered_palette_mapper_tb OK");
		else
			$display("dithered_palette_mapper_tb NOT OK");
		$finish;
	end

endmodule
